// ===== rtl/ptwc_pkg.sv =====
`default_nettype none

package ptwc_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_LEN              = 24;
    localparam int ITER_IDX_W            = 5;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int CW      = 34;
    localparam int ZW      = 35;
    localparam int PROD_W  = 51;
    localparam int ACC_W   = 52;
    localparam int CAND_W  = 27;

    localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

    localparam logic signed [COORD_W-1:0] WIN_X_MIN_RST = 16'sd0;
    localparam logic signed [COORD_W-1:0] WIN_X_MAX_RST = 16'sd639;
    localparam logic signed [COORD_W-1:0] WIN_Y_MIN_RST = 16'sd0;
    localparam logic signed [COORD_W-1:0] WIN_Y_MAX_RST = 16'sd479;

    typedef enum logic [1:0] {
        CMD_SET       = 2'd0,
        CMD_TRANSLATE = 2'd1,
        CMD_ROTATE    = 2'd2,
        CMD_SCALE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_WIN_X_MIN = 2'd0,
        REG_WIN_X_MAX = 2'd1,
        REG_WIN_Y_MIN = 2'd2,
        REG_WIN_Y_MAX = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_MUL,
        ST_DRAIN,
        ST_CAND,
        ST_CHECK
    } state_t;

    typedef enum logic [2:0] {
        MUL_DX_COS,
        MUL_DY_SIN,
        MUL_DX_SIN,
        MUL_DY_COS,
        MUL_DX_FX,
        MUL_DY_FY
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_X_LOAD,
        ACC_X_SUB,
        ACC_Y_LOAD,
        ACC_Y_ADD
    } acc_op_t;

    typedef struct packed {
        logic                  load;
        logic                  iter_en;
        logic [ITER_IDX_W-1:0] iter_idx;
        logic                  iter_last;
        logic                  mul_en;
        mul_op_t               mul_op;
        logic                  acc_en;
        acc_op_t               acc_op;
        logic                  cand_en;
        logic                  commit;
        cmd_t                  cmd;
    } dp_ctrl_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [ITER_IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 35'sd843314857;
            5'd1:    v = 35'sd497837829;
            5'd2:    v = 35'sd263043837;
            5'd3:    v = 35'sd133525159;
            5'd4:    v = 35'sd67021687;
            5'd5:    v = 35'sd33542516;
            5'd6:    v = 35'sd16775851;
            5'd7:    v = 35'sd8388437;
            5'd8:    v = 35'sd4194283;
            5'd9:    v = 35'sd2097149;
            5'd10:   v = 35'sd1048576;
            5'd11:   v = 35'sd524288;
            5'd12:   v = 35'sd262144;
            5'd13:   v = 35'sd131072;
            5'd14:   v = 35'sd65536;
            5'd15:   v = 35'sd32768;
            5'd16:   v = 35'sd16384;
            5'd17:   v = 35'sd8192;
            5'd18:   v = 35'sd4096;
            5'd19:   v = 35'sd2048;
            5'd20:   v = 35'sd1024;
            5'd21:   v = 35'sd512;
            5'd22:   v = 35'sd256;
            5'd23:   v = 35'sd128;
            default: v = 35'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ptwc_ctrl.sv =====
`default_nettype none

module ptwc_ctrl #(
    parameter int CORDIC_ITERATIONS = ptwc_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         command,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ptwc_pkg::dp_ctrl_t      dp_ctrl
);

    localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

    ptwc_pkg::state_t  state_reg, state_next;
    ptwc_pkg::cmd_t    cmd_reg, cmd_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [1:0]        step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        last_step;
    logic              in_accept;

    function automatic ptwc_pkg::mul_op_t mul_op_of(input ptwc_pkg::cmd_t c,
                                                    input logic [1:0] s);
        ptwc_pkg::mul_op_t op;
        if (c == ptwc_pkg::CMD_SCALE) begin
            op = (s == 2'd0) ? ptwc_pkg::MUL_DX_FX : ptwc_pkg::MUL_DY_FY;
        end
        else begin
            case (s)
                2'd0:    op = ptwc_pkg::MUL_DX_COS;
                2'd1:    op = ptwc_pkg::MUL_DY_SIN;
                2'd2:    op = ptwc_pkg::MUL_DX_SIN;
                default: op = ptwc_pkg::MUL_DY_COS;
            endcase
        end
        return op;
    endfunction

    function automatic ptwc_pkg::acc_op_t acc_op_of(input ptwc_pkg::cmd_t c,
                                                    input logic [1:0] s);
        ptwc_pkg::acc_op_t op;
        if (c == ptwc_pkg::CMD_SCALE) begin
            op = (s == 2'd0) ? ptwc_pkg::ACC_X_LOAD : ptwc_pkg::ACC_Y_LOAD;
        end
        else begin
            case (s)
                2'd0:    op = ptwc_pkg::ACC_X_LOAD;
                2'd1:    op = ptwc_pkg::ACC_X_SUB;
                2'd2:    op = ptwc_pkg::ACC_Y_LOAD;
                default: op = ptwc_pkg::ACC_Y_ADD;
            endcase
        end
        return op;
    endfunction

    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign last_step = (cmd_reg == ptwc_pkg::CMD_SCALE) ? 2'd1 : 2'd3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptwc_pkg::ST_IDLE;
            cmd_reg       <= ptwc_pkg::CMD_SET;
            iter_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            iter_reg      <= iter_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        iter_next      = iter_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;

        dp_ctrl           = '0;
        dp_ctrl.cmd       = cmd_reg;
        dp_ctrl.iter_idx  = ptwc_pkg::ITER_IDX_W'(iter_reg);
        dp_ctrl.iter_last = (iter_reg == ITER_LAST);
        dp_ctrl.mul_op    = mul_op_of(cmd_reg, step_reg);
        dp_ctrl.acc_op    = acc_op_of(cmd_reg, step_reg - 2'd1);

        case (state_reg)
            ptwc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_ctrl.load = 1'b1;
                    cmd_next     = ptwc_pkg::cmd_t'(command);
                    iter_next    = '0;
                    step_next    = '0;
                    case (ptwc_pkg::cmd_t'(command))
                        ptwc_pkg::CMD_ROTATE: state_next = ptwc_pkg::ST_ROT;
                        ptwc_pkg::CMD_SCALE:  state_next = ptwc_pkg::ST_MUL;
                        default:              state_next = ptwc_pkg::ST_CAND;
                    endcase
                end
            end
            ptwc_pkg::ST_ROT:
            begin
                dp_ctrl.iter_en = 1'b1;
                iter_next       = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                begin
                    state_next = ptwc_pkg::ST_MUL;
                end
            end
            ptwc_pkg::ST_MUL:
            begin
                dp_ctrl.mul_en = 1'b1;
                dp_ctrl.acc_en = (step_reg != 2'd0);
                step_next      = step_reg + 2'd1;
                if (step_reg == last_step)
                begin
                    state_next = ptwc_pkg::ST_DRAIN;
                end
            end
            ptwc_pkg::ST_DRAIN:
            begin
                dp_ctrl.acc_en = 1'b1;
                state_next     = ptwc_pkg::ST_CAND;
            end
            ptwc_pkg::ST_CAND:
            begin
                dp_ctrl.cand_en = 1'b1;
                state_next      = ptwc_pkg::ST_CHECK;
            end
            ptwc_pkg::ST_CHECK:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    dp_ctrl.commit = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ptwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptwc_pkg::ST_IDLE;
            end
        endcase
    end

    // the stored point feeds the result, so it may only move once the old result is gone
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctrl.commit |-> (!out_valid_reg || out_ready))
        else $error("commit while result still pending");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctrl.commit |=> out_valid_reg)
        else $error("result not presented after commit");

    a_iter_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctrl.iter_en |-> (cmd_reg == ptwc_pkg::CMD_ROTATE))
        else $error("cordic step outside rotate");

    a_rotate_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == ptwc_pkg::CMD_ROTATE) |=> (state_reg == ptwc_pkg::ST_ROT))
        else $error("rotate did not start cordic");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ptwc_pkg::ST_IDLE) |-> !in_ready)
        else $error("accepting while busy");

endmodule

`default_nettype wire

// ===== rtl/ptwc_datapath.sv =====
`default_nettype none

module ptwc_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic signed [15:0]   arg_x,
    input  wire logic signed [15:0]   arg_y,
    input  wire logic signed [15:0]   base_x,
    input  wire logic signed [15:0]   base_y,
    input  wire logic signed [15:0]   angle,
    input  wire logic signed [15:0]   factor_x,
    input  wire logic signed [15:0]   factor_y,
    input  wire ptwc_pkg::dp_ctrl_t   dp_ctrl,
    output logic signed [15:0]        pos_x,
    output logic signed [15:0]        pos_y,
    output logic                      applied
);

    localparam int COORD_W = ptwc_pkg::COORD_W;
    localparam int DIFF_W  = ptwc_pkg::DIFF_W;
    localparam int CW      = ptwc_pkg::CW;
    localparam int ZW      = ptwc_pkg::ZW;
    localparam int PROD_W  = ptwc_pkg::PROD_W;
    localparam int ACC_W   = ptwc_pkg::ACC_W;
    localparam int CAND_W  = ptwc_pkg::CAND_W;

    logic signed [COORD_W-1:0] win_x_min_reg, win_x_max_reg;
    logic signed [COORD_W-1:0] win_y_min_reg, win_y_max_reg;
    logic signed [COORD_W-1:0] point_x_reg, point_y_reg;
    logic                      applied_reg;

    logic signed [COORD_W-1:0] arg_x_reg, arg_y_reg, base_x_reg, base_y_reg;
    logic signed [COORD_W-1:0] factor_x_reg, factor_y_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [CW-1:0]      cx_reg, cy_reg, cx_next, cy_next;
    logic signed [ZW-1:0]      cz_reg, cz_next;
    logic                      neg_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_y_reg;
    logic signed [CAND_W-1:0]  cand_x_reg, cand_y_reg, cand_x_next, cand_y_next;

    logic signed [ZW-1:0]      z_wide, z_red;
    logic                      z_neg;
    logic signed [CW-1:0]      x_sh, y_sh, nx, ny;
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [CW-1:0]      mul_b;
    logic signed [ACC_W-1:0]   prod_ext;
    logic                      corr_rx, corr_ry, corr_sx, corr_sy;
    logic                      ok;

    assign pos_x   = point_x_reg;
    assign pos_y   = point_y_reg;
    assign applied = applied_reg;

    // angle to q.30 with reduction into minus half pi to half pi
    always_comb
    begin
        z_wide = {{2{angle[15]}}, angle, 17'b0};
        z_red  = z_wide;
        z_neg  = 1'b0;
        if (z_wide > ptwc_pkg::HALF_PI_Q30)
        begin
            z_red = z_wide - ptwc_pkg::PI_Q30;
            z_neg = 1'b1;
        end
        else if (z_wide < -ptwc_pkg::HALF_PI_Q30)
        begin
            z_red = z_wide + ptwc_pkg::PI_Q30;
            z_neg = 1'b1;
        end
    end

    // one cordic step
    always_comb
    begin
        x_sh = cx_reg >>> dp_ctrl.iter_idx;
        y_sh = cy_reg >>> dp_ctrl.iter_idx;
        if (!cz_reg[ZW-1])
        begin
            nx      = cx_reg - y_sh;
            ny      = cy_reg + x_sh;
            cz_next = cz_reg - ptwc_pkg::atan_q30(dp_ctrl.iter_idx);
        end
        else
        begin
            nx      = cx_reg + y_sh;
            ny      = cy_reg - x_sh;
            cz_next = cz_reg + ptwc_pkg::atan_q30(dp_ctrl.iter_idx);
        end
        cx_next = (dp_ctrl.iter_last && neg_reg) ? -nx : nx;
        cy_next = (dp_ctrl.iter_last && neg_reg) ? -ny : ny;
    end

    always_comb
    begin
        case (dp_ctrl.mul_op)
            ptwc_pkg::MUL_DX_COS: begin mul_a = dx_reg; mul_b = cx_reg; end
            ptwc_pkg::MUL_DY_SIN: begin mul_a = dy_reg; mul_b = cy_reg; end
            ptwc_pkg::MUL_DX_SIN: begin mul_a = dx_reg; mul_b = cy_reg; end
            ptwc_pkg::MUL_DY_COS: begin mul_a = dy_reg; mul_b = cx_reg; end
            ptwc_pkg::MUL_DX_FX:  begin mul_a = dx_reg; mul_b = CW'(factor_x_reg); end
            ptwc_pkg::MUL_DY_FY:  begin mul_a = dy_reg; mul_b = CW'(factor_y_reg); end
            default:              begin mul_a = dx_reg; mul_b = cx_reg; end
        endcase
    end

    assign prod_ext = ACC_W'(prod_reg);

    // truncation toward zero: round the floored quotient up when negative and inexact
    assign corr_rx = acc_x_reg[ACC_W-1] && (|acc_x_reg[29:0]);
    assign corr_ry = acc_y_reg[ACC_W-1] && (|acc_y_reg[29:0]);
    assign corr_sx = acc_x_reg[ACC_W-1] && (|acc_x_reg[7:0]);
    assign corr_sy = acc_y_reg[ACC_W-1] && (|acc_y_reg[7:0]);

    always_comb
    begin
        case (dp_ctrl.cmd)
            ptwc_pkg::CMD_SET:
            begin
                cand_x_next = CAND_W'(arg_x_reg);
                cand_y_next = CAND_W'(arg_y_reg);
            end
            ptwc_pkg::CMD_TRANSLATE:
            begin
                cand_x_next = CAND_W'(point_x_reg) + CAND_W'(arg_x_reg);
                cand_y_next = CAND_W'(point_y_reg) + CAND_W'(arg_y_reg);
            end
            ptwc_pkg::CMD_ROTATE:
            begin
                cand_x_next = CAND_W'(base_x_reg) + CAND_W'($signed(acc_x_reg[ACC_W-1:30]))
                              + CAND_W'(corr_rx);
                cand_y_next = CAND_W'(base_y_reg) + CAND_W'($signed(acc_y_reg[ACC_W-1:30]))
                              + CAND_W'(corr_ry);
            end
            ptwc_pkg::CMD_SCALE:
            begin
                cand_x_next = CAND_W'(base_x_reg) + acc_x_reg[CAND_W+7:8]
                              + CAND_W'(corr_sx);
                cand_y_next = CAND_W'(base_y_reg) + acc_y_reg[CAND_W+7:8]
                              + CAND_W'(corr_sy);
            end
            default:
            begin
                cand_x_next = CAND_W'(arg_x_reg);
                cand_y_next = CAND_W'(arg_y_reg);
            end
        endcase
    end

    assign ok = (cand_x_reg >= CAND_W'(win_x_min_reg)) && (cand_x_reg <= CAND_W'(win_x_max_reg))
             && (cand_y_reg >= CAND_W'(win_y_min_reg)) && (cand_y_reg <= CAND_W'(win_y_max_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_min_reg <= ptwc_pkg::WIN_X_MIN_RST;
            win_x_max_reg <= ptwc_pkg::WIN_X_MAX_RST;
            win_y_min_reg <= ptwc_pkg::WIN_Y_MIN_RST;
            win_y_max_reg <= ptwc_pkg::WIN_Y_MAX_RST;
            point_x_reg   <= '0;
            point_y_reg   <= '0;
            applied_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (ptwc_pkg::cfg_reg_t'(cfg_index))
                    ptwc_pkg::REG_WIN_X_MIN: win_x_min_reg <= cfg_data;
                    ptwc_pkg::REG_WIN_X_MAX: win_x_max_reg <= cfg_data;
                    ptwc_pkg::REG_WIN_Y_MIN: win_y_min_reg <= cfg_data;
                    ptwc_pkg::REG_WIN_Y_MAX: win_y_max_reg <= cfg_data;
                    default:                 win_x_min_reg <= win_x_min_reg;
                endcase
            end
            if (dp_ctrl.commit)
            begin
                applied_reg <= ok;
                if (ok)
                begin
                    point_x_reg <= cand_x_reg[COORD_W-1:0];
                    point_y_reg <= cand_y_reg[COORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.load)
        begin
            arg_x_reg    <= arg_x;
            arg_y_reg    <= arg_y;
            base_x_reg   <= base_x;
            base_y_reg   <= base_y;
            factor_x_reg <= factor_x;
            factor_y_reg <= factor_y;
            dx_reg       <= DIFF_W'(point_x_reg) - DIFF_W'(base_x);
            dy_reg       <= DIFF_W'(point_y_reg) - DIFF_W'(base_y);
            cx_reg       <= ptwc_pkg::CORDIC_K;
            cy_reg       <= '0;
            cz_reg       <= z_red;
            neg_reg      <= z_neg;
        end
        else if (dp_ctrl.iter_en)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;
        end
        if (dp_ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (dp_ctrl.acc_en)
        begin
            case (dp_ctrl.acc_op)
                ptwc_pkg::ACC_X_LOAD: acc_x_reg <= prod_ext;
                ptwc_pkg::ACC_X_SUB:  acc_x_reg <= acc_x_reg - prod_ext;
                ptwc_pkg::ACC_Y_LOAD: acc_y_reg <= prod_ext;
                ptwc_pkg::ACC_Y_ADD:  acc_y_reg <= acc_y_reg + prod_ext;
                default:              acc_x_reg <= prod_ext;
            endcase
        end
        if (dp_ctrl.cand_en)
        begin
            cand_x_reg <= cand_x_next;
            cand_y_reg <= cand_y_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/point_transform_with_clip.sv =====
// set and translate pass from the input transaction through the cand and check states to the result; scale
// also passes the mul and drain states first, and rotate runs the serial cordic steps before those
// one transaction in work at a time; the next can be taken as soon as the result is presented,
// so rotate throughput is set by the serial cordic and the one shared multiplier
// a pending result does not block the next input transaction
// reset (rst_n low, asynchronous) clears the point to 0,0 and loads the window 0..639 by 0..479
`default_nettype none

module point_transform_with_clip #(
    parameter int CORDIC_ITERATIONS = ptwc_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         command,
    input  wire logic signed [15:0] arg_x,
    input  wire logic signed [15:0] arg_y,
    input  wire logic signed [15:0] base_x,
    input  wire logic signed [15:0] base_y,
    input  wire logic signed [15:0] angle,
    input  wire logic signed [15:0] factor_x,
    input  wire logic signed [15:0] factor_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      pos_x,
    output logic signed [15:0]      pos_y,
    output logic                    applied
);

    ptwc_pkg::dp_ctrl_t dp_ctrl;

    ptwc_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_ctrl   (dp_ctrl)
    );

    ptwc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .arg_x     (arg_x),
        .arg_y     (arg_y),
        .base_x    (base_x),
        .base_y    (base_y),
        .angle     (angle),
        .factor_x  (factor_x),
        .factor_y  (factor_y),
        .dp_ctrl   (dp_ctrl),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .applied   (applied)
    );

endmodule

`default_nettype wire

// ===== tb/sv/point_transform_with_clip_tb.sv =====
`default_nettype none

module point_transform_with_clip_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ROT_STEPS   = ptwc_pkg::CORDIC_ITERATIONS_DEF;
    localparam longint ROT_GAIN    = 64'sd652032874;
    localparam longint ROT_PI      = 64'sd3373259426;
    localparam longint ROT_HALF_PI = 64'sd1686629713;
    localparam longint ROT_ONE     = 64'sd1073741824;
    localparam longint ROT_ATAN [0:23] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33542516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128
    };

    typedef struct packed {
        ptwc_pkg::cmd_t     cmd;
        logic signed [15:0] arg_x;
        logic signed [15:0] arg_y;
        logic signed [15:0] base_x;
        logic signed [15:0] base_y;
        logic signed [15:0] angle;
        logic signed [15:0] factor_x;
        logic signed [15:0] factor_y;
    } pt_cmd_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               applied;
    } pt_res_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic signed [15:0] arg_x;
    logic signed [15:0] arg_y;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] angle;
    logic signed [15:0] factor_x;
    logic signed [15:0] factor_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               applied;

    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] win_lim [4];
    pt_res_t            expected_pos_q [$];

    int err_cnt      = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold      = 0;
    int n_cmd [4]    = '{0, 0, 0, 0};
    int n_applied    = 0;
    int n_reg_writes = 0;

    point_transform_with_clip #(
        .CORDIC_ITERATIONS(ROT_STEPS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .arg_x    (arg_x),
        .arg_y    (arg_y),
        .base_x   (base_x),
        .base_y   (base_y),
        .angle    (angle),
        .factor_x (factor_x),
        .factor_y (factor_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .applied  (applied)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void cordic_sin_cos(input logic signed [15:0] ang,
                                           output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z    = longint'(ang) * 131072;
        x    = ROT_GAIN;
        y    = 0;
        flip = 1'b0;
        if (z > ROT_HALF_PI)
        begin
            z    = z - ROT_PI;
            flip = 1'b1;
        end
        else if (z < -ROT_HALF_PI)
        begin
            z    = z + ROT_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < ROT_STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ROT_ATAN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ROT_ATAN[i];
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    // updates the tracked point as the block would
    function automatic pt_res_t predict_point(input pt_cmd_t t);
        longint  bx;
        longint  by;
        longint  dx;
        longint  dy;
        longint  cx;
        longint  cy;
        longint  s;
        longint  c;
        pt_res_t r;
        bx = longint'(t.base_x);
        by = longint'(t.base_y);
        dx = longint'(cur_x) - bx;
        dy = longint'(cur_y) - by;
        case (t.cmd)
            ptwc_pkg::CMD_SET:
            begin
                cx = longint'(t.arg_x);
                cy = longint'(t.arg_y);
            end
            ptwc_pkg::CMD_TRANSLATE:
            begin
                cx = longint'(cur_x) + longint'(t.arg_x);
                cy = longint'(cur_y) + longint'(t.arg_y);
            end
            ptwc_pkg::CMD_ROTATE:
            begin
                cordic_sin_cos(t.angle, s, c);
                cx = bx + (dx * c - dy * s) / ROT_ONE;
                cy = by + (dx * s + dy * c) / ROT_ONE;
            end
            default:
            begin
                cx = bx + (dx * longint'(t.factor_x)) / 256;
                cy = by + (dy * longint'(t.factor_y)) / 256;
            end
        endcase
        r.applied = cx >= longint'(win_lim[ptwc_pkg::REG_WIN_X_MIN]) &&
                    cx <= longint'(win_lim[ptwc_pkg::REG_WIN_X_MAX]) &&
                    cy >= longint'(win_lim[ptwc_pkg::REG_WIN_Y_MIN]) &&
                    cy <= longint'(win_lim[ptwc_pkg::REG_WIN_Y_MAX]);
        if (r.applied)
        begin
            cur_x = cx[15:0];
            cur_y = cy[15:0];
            n_applied++;
        end
        n_cmd[t.cmd]++;
        r.pos_x = cur_x;
        r.pos_y = cur_y;
        return r;
    endfunction

    function automatic logic signed [15:0] rand16();
        case ($urandom_range(15))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_between(input int lo, input int hi);
        if (lo > hi)
            return rand16();
        return 16'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic logic signed [15:0] near(input logic signed [15:0] v, input int span);
        return 16'(int'(v) + int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic pt_cmd_t noise_cmd(input ptwc_pkg::cmd_t c);
        pt_cmd_t t;
        t.cmd      = c;
        t.arg_x    = rand16();
        t.arg_y    = rand16();
        t.base_x   = rand16();
        t.base_y   = rand16();
        t.angle    = rand16();
        t.factor_x = rand16();
        t.factor_y = rand16();
        return t;
    endfunction

    function automatic pt_cmd_t op_set(input int x, input int y);
        pt_cmd_t t;
        t       = noise_cmd(ptwc_pkg::CMD_SET);
        t.arg_x = 16'(x);
        t.arg_y = 16'(y);
        return t;
    endfunction

    function automatic pt_cmd_t op_move(input int x, input int y);
        pt_cmd_t t;
        t       = noise_cmd(ptwc_pkg::CMD_TRANSLATE);
        t.arg_x = 16'(x);
        t.arg_y = 16'(y);
        return t;
    endfunction

    function automatic pt_cmd_t op_rotate(input int bx, input int by, input int ang);
        pt_cmd_t t;
        t        = noise_cmd(ptwc_pkg::CMD_ROTATE);
        t.base_x = 16'(bx);
        t.base_y = 16'(by);
        t.angle  = 16'(ang);
        return t;
    endfunction

    function automatic pt_cmd_t op_scale(input int bx, input int by, input int fx, input int fy);
        pt_cmd_t t;
        t          = noise_cmd(ptwc_pkg::CMD_SCALE);
        t.base_x   = 16'(bx);
        t.base_y   = 16'(by);
        t.factor_x = 16'(fx);
        t.factor_y = 16'(fy);
        return t;
    endfunction

    // mostly commands that keep the point moving inside the window
    function automatic pt_cmd_t rand_cmd();
        pt_cmd_t t;
        t = noise_cmd(ptwc_pkg::cmd_t'($urandom_range(3)));
        if ($urandom_range(99) < 80)
        begin
            case (t.cmd)
                ptwc_pkg::CMD_SET:
                begin
                    t.arg_x = pick_between(win_lim[ptwc_pkg::REG_WIN_X_MIN],
                                           win_lim[ptwc_pkg::REG_WIN_X_MAX]);
                    t.arg_y = pick_between(win_lim[ptwc_pkg::REG_WIN_Y_MIN],
                                           win_lim[ptwc_pkg::REG_WIN_Y_MAX]);
                end
                ptwc_pkg::CMD_TRANSLATE:
                begin
                    t.arg_x = near(16'sd0, 64);
                    t.arg_y = near(16'sd0, 64);
                end
                ptwc_pkg::CMD_ROTATE:
                begin
                    t.base_x = near(cur_x, 100);
                    t.base_y = near(cur_y, 100);
                end
                default:
                begin
                    t.base_x   = near(cur_x, 100);
                    t.base_y   = near(cur_y, 100);
                    t.factor_x = 16'($urandom_range(512, 64));
                    t.factor_y = 16'($urandom_range(512, 64));
                    if ($urandom_range(3) == 0)
                        t.factor_x = -t.factor_x;
                    if ($urandom_range(3) == 0)
                        t.factor_y = -t.factor_y;
                end
            endcase
        end
        return t;
    endfunction

    // entered and left just after a falling edge, with in_valid low
    task automatic send_cmd(input pt_cmd_t t);
        while ($urandom_range(99) < tx_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        command  = t.cmd;
        arg_x    = t.arg_x;
        arg_y    = t.arg_y;
        base_x   = t.base_x;
        base_y   = t.base_y;
        angle    = t.angle;
        factor_x = t.factor_x;
        factor_y = t.factor_y;
        do
            @(posedge clk);
        while (!in_ready);
        expected_pos_q.push_back(predict_point(t));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_pos_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(input ptwc_pkg::cfg_reg_t r, input logic signed [15:0] v);
        cfg_we    = 1'b1;
        cfg_index = r;
        cfg_data  = v;
        @(negedge clk);
        cfg_we     = 1'b0;
        win_lim[r] = v;
        n_reg_writes++;
    endtask

    task automatic set_window(input int x_lo, input int x_hi, input int y_lo, input int y_hi);
        wait_idle();
        write_reg(ptwc_pkg::REG_WIN_X_MIN, 16'(x_lo));
        write_reg(ptwc_pkg::REG_WIN_X_MAX, 16'(x_hi));
        write_reg(ptwc_pkg::REG_WIN_Y_MIN, 16'(y_lo));
        write_reg(ptwc_pkg::REG_WIN_Y_MAX, 16'(y_hi));
    endtask

    task automatic pick_window();
        int x_lo;
        int y_lo;
        x_lo = int'($urandom_range(2000)) - 1000;
        y_lo = int'($urandom_range(2000)) - 1000;
        case ($urandom_range(4))
            0: set_window(0, 639, 0, 479);
            1: set_window(-32768, 32767, -32768, 32767);
            2: set_window(x_lo, x_lo + int'($urandom_range(4000)),
                          y_lo, y_lo + int'($urandom_range(4000)));
            3: set_window(x_lo, x_lo - int'($urandom_range(100, 1)),
                          y_lo, y_lo + int'($urandom_range(4000)));
            default: set_window(rand16(), rand16(), rand16(), rand16());
        endcase
    endtask

    task automatic test_reset_window();
        send_cmd(op_set(0, 0));
        send_cmd(op_set(639, 479));
        send_cmd(op_set(640, 479));
        send_cmd(op_set(0, -1));
        send_cmd(op_set(-32768, 32767));
        send_cmd(op_move(-639, -479));
        send_cmd(op_move(100, 50));
        send_cmd(op_rotate(0, 0, 0));
        send_cmd(op_rotate(320, 240, 25736));
        send_cmd(op_rotate(320, 240, -25736));
        send_cmd(op_rotate(320, 240, 32767));
        send_cmd(op_rotate(320, 240, -32768));
        send_cmd(op_rotate(320, 240, 12868));
        send_cmd(op_scale(0, 0, 256, 256));
        send_cmd(op_scale(0, 0, 512, -256));
        send_cmd(op_scale(320, 240, 32767, -32768));
        send_cmd(op_scale(320, 240, 0, 0));
    endtask

    task automatic test_window_bounds();
        set_window(-32768, 32767, -32768, 32767);
        send_cmd(op_set(32767, 32767));
        send_cmd(op_move(1, 0));
        send_cmd(op_move(0, 1));
        send_cmd(op_scale(-32768, -32768, 32767, 32767));
        send_cmd(op_set(-32768, -32768));
        send_cmd(op_move(-1, -1));
        send_cmd(op_rotate(32767, -32768, 12868));
        // min above max: nothing may commit
        set_window(100, 99, 0, 479);
        send_cmd(op_set(100, 0));
        // single-point window
        set_window(-5, -5, 7, 7);
        send_cmd(op_set(-5, 7));
        set_window(0, 639, 0, 479);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct  = (phase == 0) ? 13 : (phase == 1) ? 86 : 0;
            rx_stall_pct = (phase == 0) ? 86 : (phase == 1) ? 13 : 0;
            repeat (5)
            begin
                pick_window();
                repeat (50) send_cmd(rand_cmd());
            end
        end
    endtask

    task automatic test_backpressure();
        set_window(-2000, 2000, -2000, 2000);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 300;
        repeat (30) send_cmd(rand_cmd());
        wait_idle();
        repeat (10) send_cmd(rand_cmd());
    endtask

    // receiver side
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready = 1'b0;
                rx_hold--;
            end
            else
                out_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // result checker
    initial
    begin
        pt_res_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_pos_q.size() == 0)
                begin
                    $error("unexpected transaction: pos_x %0d pos_y %0d applied %0b",
                           pos_x, pos_y, applied);
                    err_cnt++;
                end
                else
                begin
                    e = expected_pos_q.pop_front();
                    if (pos_x !== e.pos_x)
                    begin
                        $error("pos_x mismatch: expected %0d, actual %0d", e.pos_x, pos_x);
                        err_cnt++;
                    end
                    if (pos_y !== e.pos_y)
                    begin
                        $error("pos_y mismatch: expected %0d, actual %0d", e.pos_y, pos_y);
                        err_cnt++;
                    end
                    if (applied !== e.applied)
                    begin
                        $error("applied mismatch: expected %0b, actual %0b", e.applied, applied);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = ptwc_pkg::REG_WIN_X_MIN;
        cfg_data  = '0;
        in_valid  = 1'b0;
        command   = ptwc_pkg::CMD_SET;
        arg_x     = '0;
        arg_y     = '0;
        base_x    = '0;
        base_y    = '0;
        angle     = '0;
        factor_x  = '0;
        factor_y  = '0;
        cur_x     = '0;
        cur_y     = '0;
        win_lim[ptwc_pkg::REG_WIN_X_MIN] = ptwc_pkg::WIN_X_MIN_RST;
        win_lim[ptwc_pkg::REG_WIN_X_MAX] = ptwc_pkg::WIN_X_MAX_RST;
        win_lim[ptwc_pkg::REG_WIN_Y_MIN] = ptwc_pkg::WIN_Y_MIN_RST;
        win_lim[ptwc_pkg::REG_WIN_Y_MAX] = ptwc_pkg::WIN_Y_MAX_RST;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_window();
        test_window_bounds();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        repeat (40) @(negedge clk);
        if (expected_pos_q.size() != 0)
        begin
            $error("%0d results never arrived", expected_pos_q.size());
            err_cnt++;
        end
        $display("covered %0d set, %0d translate, %0d rotate, %0d scale commands, %0d committed",
                 n_cmd[ptwc_pkg::CMD_SET], n_cmd[ptwc_pkg::CMD_TRANSLATE],
                 n_cmd[ptwc_pkg::CMD_ROTATE], n_cmd[ptwc_pkg::CMD_SCALE], n_applied);
        $display("%0d window register writes incl. full, empty and single-point windows",
                 n_reg_writes);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ptwc_pkg.sv
rtl/ptwc_ctrl.sv
rtl/ptwc_datapath.sv
rtl/point_transform_with_clip.sv
tb/sv/point_transform_with_clip_tb.sv
